>>> design/phd_pkg.sv
// shared constants, op codes and controller/datapath interface types for the
// point set hausdorff distance core; no dependencies
package phd_pkg;

   localparam int MAX_POINTS = 256;
   localparam int COORD_BITS = 16;

   localparam int PTR_BITS   = $clog2(MAX_POINTS);
   localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
   localparam int ABS_BITS   = COORD_BITS;
   localparam int PROD_BITS  = 2 * ABS_BITS;
   localparam int SQ_BITS    = PROD_BITS + 2;
   localparam int DIST_BITS  = SQ_BITS / 2;
   localparam int REM_BITS   = DIST_BITS + 1;
   localparam int PIPE_DEPTH = 4;
   localparam int STEP_BITS  = $clog2(DIST_BITS);

   typedef enum logic [1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_COMPUTE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } point_type;

   typedef struct packed {
      logic                load_a;
      logic                load_b;
      logic                start;
      logic                issue;
      logic                pass;
      logic [PTR_BITS-1:0] idx_src;
      logic [PTR_BITS-1:0] idx_dst;
      logic                first;
      logic                last;
      logic                root_load;
      logic                root_step;
      logic                finish;
   } cmd_type;

   typedef struct packed {
      logic [CNT_BITS-1:0] count_a;
      logic [CNT_BITS-1:0] count_b;
      logic                rsp_busy;
   } status_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } tag_type;

endpackage

>>> design/phd_ctrl.sv
// sequencer for loads, the pair sweep over both directions, pipeline drain
// and square root steps; depends on phd_pkg
module phd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_operation,
   input  phd_pkg::status_type status,
   output phd_pkg::cmd_type    cmd
);
   import phd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SWEEP,
      S_DRAIN,
      S_ROOT_LOAD,
      S_ROOT,
      S_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic                 pass_ff, pass_in;
   logic [PTR_BITS-1:0]  i_ff, i_in;
   logic [PTR_BITS-1:0]  j_ff, j_in;
   logic [STEP_BITS-1:0] step_ff, step_in;

   logic                 accept;
   logic [CNT_BITS-1:0]  n_src, n_dst;
   logic                 last_i, last_j;
   logic                 any_empty;

   assign n_src     = pass_ff ? status.count_b : status.count_a;
   assign n_dst     = pass_ff ? status.count_a : status.count_b;
   assign last_i    = ({1'b0, i_ff} == n_src - CNT_BITS'(1));
   assign last_j    = ({1'b0, j_ff} == n_dst - CNT_BITS'(1));
   assign any_empty = (status.count_a == '0) || (status.count_b == '0);

   // a compute word waits while the previous result is still unread
   assign req_ready = (state_ff == S_IDLE) &&
                      (!status.rsp_busy || (req_operation != OP_COMPUTE));
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd           = '0;
      cmd.pass      = pass_ff;
      cmd.idx_src   = i_ff;
      cmd.idx_dst   = j_ff;
      cmd.first     = (j_ff == '0);
      cmd.last      = last_j;
      cmd.load_a    = accept && (req_operation == OP_LOAD_A);
      cmd.load_b    = accept && (req_operation == OP_LOAD_B);
      cmd.start     = accept && (req_operation == OP_COMPUTE);
      cmd.issue     = (state_ff == S_SWEEP);
      cmd.root_load = (state_ff == S_ROOT_LOAD);
      cmd.root_step = (state_ff == S_ROOT);
      cmd.finish    = (state_ff == S_FINISH);
   end

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               pass_in  = 1'b0;
               i_in     = '0;
               j_in     = '0;
               state_in = any_empty ? S_ROOT_LOAD : S_SWEEP;
            end
         end
         S_SWEEP: begin
            if (last_j) begin
               j_in = '0;
               if (last_i) begin
                  i_in = '0;
                  if (pass_ff) begin
                     step_in  = '0;
                     state_in = S_DRAIN;
                  end else begin
                     pass_in = 1'b1;
                  end
               end else begin
                  i_in = i_ff + PTR_BITS'(1);
               end
            end else begin
               j_in = j_ff + PTR_BITS'(1);
            end
         end
         S_DRAIN: begin
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(PIPE_DEPTH - 1)) begin
               state_in = S_ROOT_LOAD;
            end
         end
         S_ROOT_LOAD: begin
            step_in  = '0;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(DIST_BITS - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass_ff  <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         step_ff  <= step_in;
      end
   end

endmodule

>>> design/phd_dpath.sv
// point memories, set counts, squared distance pipeline, min/max tracking,
// bit-serial square root and result register; depends on phd_pkg
module phd_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  phd_pkg::cmd_type               cmd,
   output phd_pkg::status_type            status,
   input  logic [phd_pkg::COORD_BITS-1:0] req_coord_x,
   input  logic [phd_pkg::COORD_BITS-1:0] req_coord_y,
   input  logic [phd_pkg::COORD_BITS-1:0] req_coord_z,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [phd_pkg::SQ_BITS-1:0]    rsp_squared_distance,
   output logic [phd_pkg::DIST_BITS-1:0]  rsp_distance,
   output logic                           rsp_empty_set,
   output logic                           rsp_overflow_drop
);
   import phd_pkg::*;

   point_type mem_a [MAX_POINTS];
   point_type mem_b [MAX_POINTS];

   logic [CNT_BITS-1:0] count_a_ff, count_a_in;
   logic [CNT_BITS-1:0] count_b_ff, count_b_in;
   logic                dropped_ff, dropped_in;
   logic                empty_snap_ff, drop_snap_ff;

   point_type           wr_point;
   logic [PTR_BITS-1:0] addr_a, addr_b;
   logic                full_a, full_b;

   point_type           rd_a_ff, rd_b_ff;
   tag_type             tag1_ff, tag2_ff, tag3_ff, tag4_ff;
   logic [ABS_BITS-1:0] abs_x_ff, abs_y_ff, abs_z_ff;
   logic [PROD_BITS-1:0] sq_x_ff, sq_y_ff, sq_z_ff;
   logic [SQ_BITS-1:0]  sum_ff;
   logic [SQ_BITS-1:0]  best_ff, worst_ff;
   logic [SQ_BITS-1:0]  cur_best;

   logic signed [COORD_BITS:0] dx, dy, dz;

   logic [SQ_BITS-1:0]   rad_ff;
   logic [REM_BITS-1:0]  rem_ff;
   logic [DIST_BITS-1:0] root_ff;
   logic [REM_BITS+1:0]  rem_sh, trial;

   logic                 rsp_valid_ff;
   logic [SQ_BITS-1:0]   rsp_sq_ff;
   logic [DIST_BITS-1:0] rsp_dist_ff;
   logic                 rsp_empty_ff, rsp_drop_ff;

   assign wr_point = '{x: req_coord_x, y: req_coord_y, z: req_coord_z};
   assign full_a   = (count_a_ff == CNT_BITS'(MAX_POINTS));
   assign full_b   = (count_b_ff == CNT_BITS'(MAX_POINTS));

   // set counts and the sticky drop flag
   always_comb begin
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      dropped_in = dropped_ff;
      priority if (cmd.finish) begin
         count_a_in = '0;
         count_b_in = '0;
         dropped_in = 1'b0;
      end else if (cmd.load_a) begin
         if (full_a) dropped_in = 1'b1;
         else        count_a_in = count_a_ff + CNT_BITS'(1);
      end else if (cmd.load_b) begin
         if (full_b) dropped_in = 1'b1;
         else        count_b_in = count_b_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff <= '0;
         count_b_ff <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         empty_snap_ff <= (count_a_ff == '0) || (count_b_ff == '0);
         drop_snap_ff  <= dropped_ff;
      end
   end

   assign status = '{count_a: count_a_ff, count_b: count_b_ff, rsp_busy: rsp_valid_ff};

   // pass 0 walks a as source, pass 1 walks b as source
   assign addr_a = cmd.pass ? cmd.idx_dst : cmd.idx_src;
   assign addr_b = cmd.pass ? cmd.idx_src : cmd.idx_dst;

   always_ff @(posedge clock) begin
      if (cmd.load_a && !full_a) begin
         mem_a[count_a_ff[PTR_BITS-1:0]] <= wr_point;
      end
      rd_a_ff <= mem_a[addr_a];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_b && !full_b) begin
         mem_b[count_b_ff[PTR_BITS-1:0]] <= wr_point;
      end
      rd_b_ff <= mem_b[addr_b];
   end

   // distance is symmetric, so the pipeline need not know which side is source
   assign dx = {rd_a_ff.x[COORD_BITS-1], rd_a_ff.x} - {rd_b_ff.x[COORD_BITS-1], rd_b_ff.x};
   assign dy = {rd_a_ff.y[COORD_BITS-1], rd_a_ff.y} - {rd_b_ff.y[COORD_BITS-1], rd_b_ff.y};
   assign dz = {rd_a_ff.z[COORD_BITS-1], rd_a_ff.z} - {rd_b_ff.z[COORD_BITS-1], rd_b_ff.z};

   always_ff @(posedge clock) begin
      abs_x_ff <= dx[COORD_BITS] ? ABS_BITS'(-dx) : ABS_BITS'(dx);
      abs_y_ff <= dy[COORD_BITS] ? ABS_BITS'(-dy) : ABS_BITS'(dy);
      abs_z_ff <= dz[COORD_BITS] ? ABS_BITS'(-dz) : ABS_BITS'(dz);
      sq_x_ff  <= abs_x_ff * abs_x_ff;
      sq_y_ff  <= abs_y_ff * abs_y_ff;
      sq_z_ff  <= abs_z_ff * abs_z_ff;
      sum_ff   <= SQ_BITS'(sq_x_ff) + SQ_BITS'(sq_y_ff) + SQ_BITS'(sq_z_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
      end else begin
         tag1_ff <= '{valid: cmd.issue, first: cmd.first, last: cmd.last};
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
      end
   end

   // running min over the destination set, max of those minima overall
   assign cur_best = (tag4_ff.first || (sum_ff < best_ff)) ? sum_ff : best_ff;

   always_ff @(posedge clock) begin
      if (tag4_ff.valid) begin
         best_ff <= cur_best;
      end
      if (cmd.start) begin
         worst_ff <= '0;
      end else if (tag4_ff.valid && tag4_ff.last && (cur_best > worst_ff)) begin
         worst_ff <= cur_best;
      end
   end

   // restoring square root, one result bit a step
   assign rem_sh = {rem_ff, rad_ff[SQ_BITS-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.root_load) begin
         rad_ff  <= worst_ff;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff <= {rad_ff[SQ_BITS-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= REM_BITS'(rem_sh - trial);
            root_ff <= {root_ff[DIST_BITS-2:0], 1'b1};
         end else begin
            rem_ff  <= REM_BITS'(rem_sh);
            root_ff <= {root_ff[DIST_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_sq_ff    <= worst_ff;
         rsp_dist_ff  <= root_ff;
         rsp_empty_ff <= empty_snap_ff;
         rsp_drop_ff  <= drop_snap_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_squared_distance = rsp_sq_ff;
   assign rsp_distance         = rsp_dist_ff;
   assign rsp_empty_set        = rsp_empty_ff;
   assign rsp_overflow_drop    = rsp_drop_ff;

endmodule

>>> design/point_set_hausdorff_distance_core.sv
// symmetric hausdorff distance of two 3d point sets; uses phd_pkg, phd_ctrl, phd_dpath
// load words: one per cycle when idle, no result word; a compute word waits while a result is unread
// compute word: the single pair pipeline walks every a/b pair once in each direction,
//   then a 4-stage drain and a 17-step square root follow; empty sets skip the sweep
//   and the drain
// reset: clears set counts, drop flag, controller and result valid; point memories keep contents
module point_set_hausdorff_distance_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_operation,
   input  logic [phd_pkg::COORD_BITS-1:0] req_coord_x,
   input  logic [phd_pkg::COORD_BITS-1:0] req_coord_y,
   input  logic [phd_pkg::COORD_BITS-1:0] req_coord_z,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [phd_pkg::SQ_BITS-1:0]    rsp_squared_distance,
   output logic [phd_pkg::DIST_BITS-1:0]  rsp_distance,
   output logic                           rsp_empty_set,
   output logic                           rsp_overflow_drop
);
   import phd_pkg::*;

   cmd_type    cmd;
   status_type status;

   phd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd)
   );

   phd_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_coord_x          (req_coord_x),
      .req_coord_y          (req_coord_y),
      .req_coord_z          (req_coord_z),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_squared_distance (rsp_squared_distance),
      .rsp_distance         (rsp_distance),
      .rsp_empty_set        (rsp_empty_set),
      .rsp_overflow_drop    (rsp_overflow_drop)
   );

endmodule

>>> tb/sv/tb_point_set_hausdorff_distance_core.sv
// self-checking testbench for point_set_hausdorff_distance_core: drives point and compute
// words with random idling and checks every result word against a scoreboard predictor
// depends on phd_pkg and the core rtl
`timescale 1ns / 100ps

module tb_point_set_hausdorff_distance_core;
   import phd_pkg::*;

   localparam int CYCLE_LIMIT     = 2_000_000;
   localparam int RSP_HOLD_CYCLES = 3000;
   localparam int DRAIN_CYCLES    = 60;
   localparam int TARGET_WORDS    = 1900;

   typedef struct packed {
      logic [SQ_BITS-1:0]   sq;
      logic [DIST_BITS-1:0] root;
      logic                 empty;
      logic                 drop;
   } distance_word_type;

   class hausdorff_predictor;
      point_type         set_a [MAX_POINTS];
      point_type         set_b [MAX_POINTS];
      int                count_a = 0;
      int                count_b = 0;
      bit                dropped = 0;
      int                mismatches = 0;
      distance_word_type expected_distances [$];

      function longint unsigned pair_sq(point_type p, point_type q);
         longint          dx, dy, dz;
         dx = longint'($signed(p.x)) - longint'($signed(q.x));
         dy = longint'($signed(p.y)) - longint'($signed(q.y));
         dz = longint'($signed(p.z)) - longint'($signed(q.z));
         return longint'(dx * dx + dy * dy + dz * dz);
      endfunction

      // largest over one set of the nearest squared distance into the other
      function longint unsigned farthest_nearest(bit from_a);
         int              ns, nd;
         longint unsigned worst, best, d;
         point_type       p, q;
         ns = from_a ? count_a : count_b;
         nd = from_a ? count_b : count_a;
         worst = 0;
         for (int i = 0; i < ns; i++) begin
            p = from_a ? set_a[i] : set_b[i];
            best = '1;
            for (int j = 0; j < nd; j++) begin
               q = from_a ? set_b[j] : set_a[j];
               d = pair_sq(p, q);
               if (d < best) best = d;
            end
            if (best > worst) worst = best;
         end
         return worst;
      endfunction

      function longint unsigned floor_root(longint unsigned v);
         longint unsigned r, t;
         r = 0;
         for (int b = DIST_BITS; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v) r = t;
         end
         return r;
      endfunction

      function void note_word(op_type op, point_type p);
         distance_word_type r;
         longint unsigned   ab, ba, sq;
         case (op)
            OP_LOAD_A: begin
               if (count_a >= MAX_POINTS) dropped = 1;
               else begin
                  set_a[count_a] = p;
                  count_a++;
               end
            end
            OP_LOAD_B: begin
               if (count_b >= MAX_POINTS) dropped = 1;
               else begin
                  set_b[count_b] = p;
                  count_b++;
               end
            end
            OP_COMPUTE: begin
               sq = 0;
               r.empty = (count_a == 0 || count_b == 0);
               if (!r.empty) begin
                  ab = farthest_nearest(1'b1);
                  ba = farthest_nearest(1'b0);
                  sq = (ab > ba) ? ab : ba;
               end
               r.sq   = sq[SQ_BITS-1:0];
               r.root = DIST_BITS'(floor_root(sq));
               r.drop = dropped;
               expected_distances = {expected_distances, r};
               count_a = 0;
               count_b = 0;
               dropped = 0;
            end
            default: ;
         endcase
      endfunction

      function void check_distance(distance_word_type got);
         distance_word_type want;
         if (expected_distances.size() == 0) begin
            $error("result word with none expected: squared_distance %0d", got.sq);
            mismatches++;
            return;
         end
         want = expected_distances.pop_front();
         if (got.sq !== want.sq) begin
            $error("squared_distance: expected %0d, got %0d", want.sq, got.sq);
            mismatches++;
         end
         if (got.root !== want.root) begin
            $error("distance: expected %0d, got %0d", want.root, got.root);
            mismatches++;
         end
         if (got.empty !== want.empty) begin
            $error("empty_set: expected %0d, got %0d", want.empty, got.empty);
            mismatches++;
         end
         if (got.drop !== want.drop) begin
            $error("overflow_drop: expected %0d, got %0d", want.drop, got.drop);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_operation;
   logic [COORD_BITS-1:0] req_coord_x;
   logic [COORD_BITS-1:0] req_coord_y;
   logic [COORD_BITS-1:0] req_coord_z;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [SQ_BITS-1:0]    rsp_squared_distance;
   logic [DIST_BITS-1:0]  rsp_distance;
   logic                  rsp_empty_set;
   logic                  rsp_overflow_drop;

   hausdorff_predictor predictor = new();
   int                 cycles = 0;
   int                 words_sent = 0;
   bit                 no_idle = 1'b0;
   bit                 hold_rsp = 1'b0;

   point_set_hausdorff_distance_core DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_operation        (req_operation),
      .req_coord_x          (req_coord_x),
      .req_coord_y          (req_coord_y),
      .req_coord_z          (req_coord_z),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_squared_distance (rsp_squared_distance),
      .rsp_distance         (rsp_distance),
      .rsp_empty_set        (rsp_empty_set),
      .rsp_overflow_drop    (rsp_overflow_drop)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         predictor.check_distance({rsp_squared_distance, rsp_distance,
                                   rsp_empty_set, rsp_overflow_drop});
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic point_type pt(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      point_type p;
      p.x = x;
      p.y = y;
      p.z = z;
      return p;
   endfunction

   function automatic logic [15:0] extreme_coord();
      case ($urandom_range(0, 3))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         default: return 16'hffff;
      endcase
   endfunction

   // style 0..1 full range, 2 extremes, otherwise a cluster around center
   function automatic point_type random_point(int style, point_type center);
      point_type p;
      if (style < 2) begin
         p = pt(16'($urandom), 16'($urandom), 16'($urandom));
      end else if (style == 2) begin
         p = pt(extreme_coord(), extreme_coord(), extreme_coord());
      end else begin
         p.x = center.x + 16'($urandom_range(0, 63)) - 16'd32;
         p.y = center.y + 16'($urandom_range(0, 63)) - 16'd32;
         p.z = center.z + 16'($urandom_range(0, 63)) - 16'd32;
      end
      return p;
   endfunction

   function automatic int set_size();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 0;
      if (r < 17) return $urandom_range(1, 8);
      return $urandom_range(9, 24);
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_word(op_type op, point_type p);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_coord_x   <= p.x;
      req_coord_y   <= p.y;
      req_coord_z   <= p.z;
      do @(posedge clock); while (!req_ready);
      predictor.note_word(op, p);
      if (op != OP_NONE) words_sent++;
      @(negedge clock);
   endtask

   task automatic send_group(int na, int nb, bit with_compute);
      int        ia, ib, style;
      point_type center;
      ia = 0;
      ib = 0;
      style = $urandom_range(0, 9);
      center = pt(16'($urandom), 16'($urandom), 16'($urandom));
      while (ia < na || ib < nb) begin
         if ($urandom_range(0, 19) == 0) send_word(OP_NONE, random_point(0, center));
         if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
            send_word(OP_LOAD_A, random_point(style, center));
            ia++;
         end else begin
            send_word(OP_LOAD_B, random_point(style, center));
            ib++;
         end
      end
      if (with_compute) send_word(OP_COMPUTE, random_point(0, center));
   endtask

   // result side: random stalls, ready stretches, and one long hold on request
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (no_idle) begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end else if ($urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat (pick_gap() + 1) @(negedge clock);
         end
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = OP_NONE;
      req_coord_x   = '0;
      req_coord_y   = '0;
      req_coord_z   = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // both sets empty, then one side empty
      send_word(OP_COMPUTE, pt(16'h0000, 16'h0000, 16'h0000));
      send_word(OP_LOAD_A, pt(16'h8000, 16'h8000, 16'h8000));
      send_word(OP_COMPUTE, pt(16'hffff, 16'hffff, 16'hffff));
      send_word(OP_LOAD_B, pt(16'h7fff, 16'h7fff, 16'h7fff));
      send_word(OP_COMPUTE, pt(16'h0000, 16'h0000, 16'h0000));
      // opposite corners give the largest distance
      send_word(OP_LOAD_A, pt(16'h8000, 16'h8000, 16'h8000));
      send_word(OP_LOAD_B, pt(16'h7fff, 16'h7fff, 16'h7fff));
      send_word(OP_COMPUTE, pt(16'h5555, 16'haaaa, 16'h5555));
      // coincident points, unused op in between is ignored
      send_word(OP_LOAD_A, pt(16'h0000, 16'h0000, 16'h0000));
      send_word(OP_NONE, pt(16'h7fff, 16'h8000, 16'hffff));
      send_word(OP_LOAD_B, pt(16'h0000, 16'h0000, 16'h0000));
      send_word(OP_COMPUTE, pt(16'h0000, 16'h0000, 16'h0000));
      // asymmetric sets so the two directions differ
      send_word(OP_LOAD_A, pt(16'h7fff, 16'h8000, 16'h0000));
      send_word(OP_LOAD_A, pt(16'h0010, 16'h0020, 16'hfff0));
      send_word(OP_LOAD_B, pt(16'h8000, 16'h7fff, 16'h0000));
      send_word(OP_LOAD_B, pt(16'h7fff, 16'h8000, 16'h0001));
      send_word(OP_LOAD_B, pt(16'h0013, 16'h0024, 16'hfff0));
      send_word(OP_COMPUTE, pt(16'h0000, 16'h0000, 16'h0000));
      send_word(OP_LOAD_B, pt(16'h0001, 16'h0001, 16'h0001));
      send_word(OP_LOAD_A, pt(16'hffff, 16'hffff, 16'hffff));
      send_word(OP_LOAD_B, pt(16'hfffb, 16'h0005, 16'hfffd));
      send_word(OP_COMPUTE, pt(16'h0000, 16'h0000, 16'h0000));

      // results back up while the sender keeps going
      hold_rsp = 1'b1;
      repeat (5) send_group($urandom_range(1, 4), $urandom_range(1, 4), 1'b1);

      // full sets with dropped loads
      send_group(MAX_POINTS + 2, 2, 1'b1);
      send_group(MAX_POINTS, MAX_POINTS + 1, 1'b1);

      while (words_sent < TARGET_WORDS) begin
         no_idle = ($urandom_range(0, 7) == 0);
         send_group(set_size(), set_size(), $urandom_range(0, 19) != 0);
         if ($urandom_range(0, 29) == 0) send_word(OP_COMPUTE, pt(16'h0, 16'h0, 16'h0));
      end
      no_idle = 1'b0;
      send_word(OP_COMPUTE, pt(16'h0000, 16'h0000, 16'h0000));
      req_valid <= 1'b0;

      while (predictor.expected_distances.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (predictor.mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
